/* hw/rtl/unique_page_sorted_collector_macros.svh */
// Assertion macros for the unique page sorted collector.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef UNIQUE_PAGE_SORTED_COLLECTOR_MACROS_SVH
`define UNIQUE_PAGE_SORTED_COLLECTOR_MACROS_SVH

// same-cycle implication
`define UPSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UPSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/upsc_pkg.sv */
// Shared types and constants for the unique page sorted collector.
// No dependencies.
package upsc_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned PAGE_W   = 64;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // register index, taken from paddr[2]
  localparam logic REG_TRACE_MODE = 1'b0;
  localparam logic REG_PAGE_SHIFT = 1'b1;

  typedef struct packed {
    logic               trace_mode;
    logic [SHIFT_W-1:0] page_shift;
  } cfg_t;

  typedef struct packed {
    logic insert;  // place page_i into the sorted chain
    logic emit;    // shift the chain one cell toward cell 0
  } cell_ctrl_t;

endpackage

/* hw/rtl/unique_page_sorted_collector.sv */
// A trace_end request is registered in pend_q and last_q, which then raise emit_q for the first result;
// results follow at one result per cycle; busy stays high until the last result is shown.
// Throughput: one address per cycle while busy is low; the cell chain inserts each page as the next is registered.
// Reset: asynchronous, active low; empties the table and loads trace_mode 0, page_shift 6.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Depends on upsc_pkg, upsc_cfg, upsc_cell and the assertion macro header.
`include "unique_page_sorted_collector_macros.svh"
module unique_page_sorted_collector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [upsc_pkg::DATA_W-1:0]   pwdata,
  output logic [upsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [upsc_pkg::PAGE_W-1:0]   address_i,
  input  logic                          trace_end_i,
  output logic                          result_valid_o,
  output logic [upsc_pkg::PAGE_W-1:0]   page_o,
  output logic [upsc_pkg::RANK_W-1:0]   rank_o,
  output logic [upsc_pkg::CNT_W-1:0]    unique_count_o,
  output logic                          overflowed_o,
  output logic                          final_result_o
);

  localparam int unsigned Cap = upsc_pkg::CAPACITY;

  upsc_pkg::cfg_t       cfg;
  upsc_pkg::cell_ctrl_t ctrl;

  logic                          pend_q, pend_d;
  logic                          last_q, last_d;
  logic [upsc_pkg::PAGE_W-1:0]   pg_q, pg_d;
  logic                          emit_q, emit_d;
  logic                          ovf_q, ovf_d;
  logic [upsc_pkg::CNT_W-1:0]    count_q, count_d;
  logic [upsc_pkg::RANK_W-1:0]   rank_q, rank_d;

  logic [upsc_pkg::PAGE_W-1:0]   value_w [Cap];
  logic [Cap-1:0]                lt_w;
  logic [Cap-1:0]                eq_w;
  logic [Cap-1:0]                valid_w;

  logic accept, dup, full, ins, final_w;

  upsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign ctrl.insert = ins;
  assign ctrl.emit   = emit_q;

  for (genvar g = 0; g < Cap; g++) begin : g_cell
    logic                        left_lt;
    logic [upsc_pkg::PAGE_W-1:0] left_value;
    logic [upsc_pkg::PAGE_W-1:0] right_value;

    assign valid_w[g] = (count_q > upsc_pkg::CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = pg_q;
    end else begin : g_body
      assign left_lt    = lt_w[g-1];
      assign left_value = value_w[g-1];
    end

    if (g == Cap - 1) begin : g_tail
      assign right_value = value_w[g];
    end else begin : g_mid
      assign right_value = value_w[g+1];
    end

    upsc_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .page_i        (pg_q),
      .valid_i       (valid_w[g]),
      .left_lt_i     (left_lt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (value_w[g]),
      .lt_o          (lt_w[g]),
      .eq_o          (eq_w[g])
    );
  end

  assign busy    = (pend_q && last_q) || emit_q;
  assign accept  = start && !busy;
  assign dup     = |eq_w;
  assign full    = (count_q == upsc_pkg::CNT_W'(Cap));
  assign ins     = pend_q && !dup && !full;
  assign final_w = emit_q &&
                   ((upsc_pkg::CNT_W'(rank_q) + upsc_pkg::CNT_W'(1)) == count_q);

  always_comb begin
    pend_d  = accept;
    last_d  = accept && trace_end_i;
    pg_d    = cfg.trace_mode ? address_i : (address_i >> cfg.page_shift);
    emit_d  = emit_q;
    ovf_d   = ovf_q;
    count_d = count_q;
    rank_d  = rank_q;

    if (ins) begin
      count_d = count_q + upsc_pkg::CNT_W'(1);
    end
    if (pend_q && !dup && full) begin
      ovf_d = 1'b1;
    end
    if (pend_q && last_q) begin
      emit_d = 1'b1;
      rank_d = '0;
    end

    if (emit_q) begin
      rank_d = rank_q + upsc_pkg::RANK_W'(1);
      if (final_w) begin
        emit_d  = 1'b0;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      emit_q  <= 1'b0;
      ovf_q   <= 1'b0;
      count_q <= '0;
      rank_q  <= '0;
    end else begin
      pend_q  <= pend_d;
      last_q  <= last_d;
      emit_q  <= emit_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q <= pg_d;
  end

  assign result_valid_o = emit_q;
  assign page_o         = value_w[0];
  assign rank_o         = rank_q;
  assign unique_count_o = count_q;
  assign overflowed_o   = ovf_q;
  assign final_result_o = final_w;

  `UPSC_ASSERT_NXT(a_end_blocks, accept && trace_end_i, busy, "trace end did not raise busy")
  `UPSC_ASSERT_NXT(a_final_stops, result_valid_o && final_result_o, !result_valid_o,
                   "results continue after final")
  `UPSC_ASSERT_IMP(a_count_cap, 1'b1, count_q <= upsc_pkg::CNT_W'(Cap), "entry count over capacity")
  `UPSC_ASSERT_IMP(a_rank_range, result_valid_o, upsc_pkg::CNT_W'(rank_q) < count_q,
                   "rank beyond entry count")
  `UPSC_ASSERT_IMP(a_no_ins_emit, ins, !emit_q, "insert during emission")

endmodule

/* hw/rtl/upsc_cfg.sv */
// APB-style configuration registers: trace mode and page shift.
// Depends on upsc_pkg.
module upsc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [upsc_pkg::DATA_W-1:0]   pwdata,
  output logic [upsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output upsc_pkg::cfg_t                cfg_o
);

  upsc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        upsc_pkg::REG_TRACE_MODE: cfg_d.trace_mode = pwdata[0];
        upsc_pkg::REG_PAGE_SHIFT: cfg_d.page_shift = pwdata[upsc_pkg::SHIFT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      upsc_pkg::REG_TRACE_MODE: prdata = {{(upsc_pkg::DATA_W-1){1'b0}}, cfg_q.trace_mode};
      upsc_pkg::REG_PAGE_SHIFT:
        prdata = {{(upsc_pkg::DATA_W-upsc_pkg::SHIFT_W){1'b0}}, cfg_q.page_shift};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trace_mode <= 1'b0;
      cfg_q.page_shift <= upsc_pkg::SHIFT_W'(6);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/upsc_cell.sv */
// One insertion cell of the sorted page chain.
// Depends on upsc_pkg.
module upsc_cell (
  input  logic                          clk_i,
  input  upsc_pkg::cell_ctrl_t          ctrl_i,
  input  logic [upsc_pkg::PAGE_W-1:0]   page_i,
  input  logic                          valid_i,
  input  logic                          left_lt_i,
  input  logic [upsc_pkg::PAGE_W-1:0]   left_value_i,
  input  logic [upsc_pkg::PAGE_W-1:0]   right_value_i,
  output logic [upsc_pkg::PAGE_W-1:0]   value_o,
  output logic                          lt_o,
  output logic                          eq_o
);

  logic [upsc_pkg::PAGE_W-1:0] value_q, value_d;

  assign lt_o = valid_i && (value_q < page_i);
  assign eq_o = valid_i && (value_q == page_i);

  // cells below the insert point keep, the first at or above takes the page,
  // the rest take their left neighbor; on emit every cell takes its right neighbor
  always_comb begin
    value_d = value_q;
    if (ctrl_i.emit) begin
      value_d = right_value_i;
    end else if (ctrl_i.insert && !lt_o) begin
      value_d = left_lt_i ? page_i : left_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* verif/unique_page_sorted_collector_tb.sv */
// Self-checking testbench for unique_page_sorted_collector: random traces with
// repeats, overflow and register changes, checked against an in-bench page table.
// Depends on upsc_pkg and the unique_page_sorted_collector RTL.
`timescale 1ns / 1ps
module unique_page_sorted_collector_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned SETTLE_CYC = 4;
  localparam logic [upsc_pkg::ADDR_W-1:0] TRACE_MODE_ADDR = {upsc_pkg::REG_TRACE_MODE, 2'b00};
  localparam logic [upsc_pkg::ADDR_W-1:0] PAGE_SHIFT_ADDR = {upsc_pkg::REG_PAGE_SHIFT, 2'b00};

  typedef struct {
    logic [upsc_pkg::PAGE_W-1:0] addr;
    logic                        last;
    int unsigned                 gap;
    bit                          hold;  // wait for all pending results before sending
  } trace_req_t;

  typedef struct {
    logic [upsc_pkg::PAGE_W-1:0] page;
    logic [upsc_pkg::RANK_W-1:0] rank;
    logic [upsc_pkg::CNT_W-1:0]  count;
    logic                        ovf;
    logic                        fin;
  } page_res_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [upsc_pkg::ADDR_W-1:0]   paddr          = '0;
  logic [upsc_pkg::DATA_W-1:0]   pwdata         = '0;
  logic [upsc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          start          = 1'b0;
  logic                          busy;
  logic [upsc_pkg::PAGE_W-1:0]   address_i      = '0;
  logic                          trace_end_i    = 1'b0;
  logic                          result_valid_o;
  logic [upsc_pkg::PAGE_W-1:0]   page_o;
  logic [upsc_pkg::RANK_W-1:0]   rank_o;
  logic [upsc_pkg::CNT_W-1:0]    unique_count_o;
  logic                          overflowed_o;
  logic                          final_result_o;

  unique_page_sorted_collector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .address_i      (address_i),
    .trace_end_i    (trace_end_i),
    .result_valid_o (result_valid_o),
    .page_o         (page_o),
    .rank_o         (rank_o),
    .unique_count_o (unique_count_o),
    .overflowed_o   (overflowed_o),
    .final_result_o (final_result_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  trace_req_t        addr_req_q[$];
  page_res_t         page_exp_q[$];
  int unsigned       fail_cnt  = 0;
  int unsigned       idle_cyc  = 0;
  int unsigned       gap_cnt   = 0;

  // in-bench copy of the sorted page table and registers
  logic [upsc_pkg::PAGE_W-1:0]  page_tbl [upsc_pkg::CAPACITY];
  int unsigned                  page_cnt  = 0;
  logic                         page_ovf  = 1'b0;
  logic                         cfg_mode  = 1'b0;
  logic [upsc_pkg::SHIFT_W-1:0] cfg_shift = 6'd6;

  function automatic logic [upsc_pkg::PAGE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void file_page(input logic [upsc_pkg::PAGE_W-1:0] pg);
    int unsigned pos;
    int unsigned k;
    pos = 0;
    while (pos < page_cnt && page_tbl[pos] < pg) pos++;
    if (pos < page_cnt && page_tbl[pos] == pg) return;
    if (page_cnt >= upsc_pkg::CAPACITY) begin
      page_ovf = 1'b1;
      return;
    end
    for (k = page_cnt; k > pos; k--) page_tbl[k] = page_tbl[k - 1];
    page_tbl[pos] = pg;
    page_cnt++;
  endfunction

  function automatic void predict_pages(input logic [upsc_pkg::PAGE_W-1:0] addr,
                                        input logic last);
    page_res_t   res;
    int unsigned r;
    file_page(cfg_mode ? addr : (addr >> cfg_shift));
    if (last) begin
      for (r = 0; r < page_cnt; r++) begin
        res.page  = page_tbl[r];
        res.rank  = upsc_pkg::RANK_W'(r);
        res.count = upsc_pkg::CNT_W'(page_cnt);
        res.ovf   = page_ovf;
        res.fin   = (r + 1 == page_cnt);
        page_exp_q.push_back(res);
      end
      page_cnt = 0;
      page_ovf = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // driver: one start assignment per edge; a held request also waits when a
  // trace end is taken at this very edge
  always @(posedge clk_i) begin
    trace_req_t cur;
    if (!rst_ni) begin
      start   <= 1'b0;
      gap_cnt <= 0;
    end else if (!start || !busy) begin
      if (addr_req_q.size() != 0 && gap_cnt >= addr_req_q[0].gap &&
          (!addr_req_q[0].hold ||
           (page_exp_q.size() == 0 && !(start && trace_end_i)))) begin
        cur = addr_req_q.pop_front();
        start       <= 1'b1;
        address_i   <= cur.addr;
        trace_end_i <= cur.last;
        gap_cnt     <= 0;
      end else begin
        start <= 1'b0;
        if (addr_req_q.size() != 0) gap_cnt <= gap_cnt + 1;
      end
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk_i) begin
    page_res_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (page_exp_q.size() == 0) begin
          $error("unexpected result: page %0h", page_o);
          fail_cnt++;
        end else begin
          exp_r = page_exp_q.pop_front();
          check_field("page", exp_r.page, page_o);
          check_field("rank", 64'(exp_r.rank), 64'(rank_o));
          check_field("unique_count", 64'(exp_r.count), 64'(unique_count_o));
          check_field("overflowed", 64'(exp_r.ovf), 64'(overflowed_o));
          check_field("final_result", 64'(exp_r.fin), 64'(final_result_o));
        end
      end
      if (start && !busy) predict_pages(address_i, trace_end_i);
    end
  end

  // unexpected results do not count as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || (result_valid_o && page_exp_q.size() != 0) ||
          (psel && penable && pready))
        idle_cyc <= 0;
      else
        idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    wait (idle_cyc >= IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic void push_req(input logic [upsc_pkg::PAGE_W-1:0] addr, input logic last,
                                   input int unsigned gap, input bit hold);
    trace_req_t req;
    req.addr = addr;
    req.last = last;
    req.gap  = gap;
    req.hold = hold;
    addr_req_q.push_back(req);
  endfunction

  function automatic logic [upsc_pkg::PAGE_W-1:0] pick_page();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return upsc_pkg::PAGE_W'($urandom_range(0, 15));
      default: return rand64();
    endcase
  endfunction

  // pool_sz 0: every address is fresh noise
  function automatic void add_trace(input int unsigned len, input int unsigned pool_sz);
    logic [upsc_pkg::PAGE_W-1:0] pool[$];
    logic [upsc_pkg::PAGE_W-1:0] v;
    logic [upsc_pkg::PAGE_W-1:0] addr;
    logic [upsc_pkg::PAGE_W-1:0] low_mask;
    bit                          pace;
    int unsigned                 i;
    pace = ($urandom_range(0, 1) == 1);
    low_mask = (64'd1 << cfg_shift) - 64'd1;
    for (i = 0; i < pool_sz; i++) pool.push_back(pick_page());
    for (i = 0; i < len; i++) begin
      if (pool_sz == 0 || $urandom_range(0, 7) == 0) begin
        addr = rand64();
      end else begin
        v = pool[$urandom_range(0, pool_sz - 1)];
        addr = cfg_mode ? v : ((v << cfg_shift) | (rand64() & low_mask));
      end
      push_req(addr, i + 1 == len, pace ? $urandom_range(0, 8) : 0,
               i == 0 && $urandom_range(0, 5) == 0);
    end
  endfunction

  function automatic void add_random_traces(input int unsigned budget,
                                            input int unsigned noise_len);
    int unsigned n;
    int unsigned len;
    n = 0;
    if (noise_len != 0) begin
      add_trace(noise_len, 0);
      n = noise_len;
    end
    while (n < budget) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      add_trace(len, $urandom_range(1, len));
      n += len;
    end
  endfunction

  task automatic wait_idle();
    while (addr_req_q.size() != 0 || start || page_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic [upsc_pkg::ADDR_W-1:0] addr, input logic wr,
                            input logic [upsc_pkg::DATA_W-1:0] wdata,
                            output logic [upsc_pkg::DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [upsc_pkg::ADDR_W-1:0] addr,
                           input logic [upsc_pkg::DATA_W-1:0] exp_v,
                           input string name);
    logic [upsc_pkg::DATA_W-1:0] rd;
    apb_access(addr, 1'b0, '0, rd);
    check_field(name, 64'(exp_v), 64'(rd));
  endtask

  // upper data bits are junk on purpose; only the low bits must stick
  task automatic set_config(input logic mode, input logic [upsc_pkg::SHIFT_W-1:0] shift);
    logic [upsc_pkg::DATA_W-1:0] rd;
    wait_idle();
    apb_access(TRACE_MODE_ADDR, 1'b1, ($urandom & ~32'd1) | upsc_pkg::DATA_W'(mode), rd);
    cfg_mode = mode;
    apb_access(PAGE_SHIFT_ADDR, 1'b1, ($urandom & ~32'h3f) | upsc_pkg::DATA_W'(shift), rd);
    cfg_shift = shift;
    check_reg(TRACE_MODE_ADDR, upsc_pkg::DATA_W'(mode), "trace_mode");
    check_reg(PAGE_SHIFT_ADDR, upsc_pkg::DATA_W'(shift), "page_shift");
  endtask

  initial begin
    logic                         phase_mode  [7];
    logic [upsc_pkg::SHIFT_W-1:0] phase_shift [7];
    int unsigned                  phase_noise [7];
    int unsigned                  p;
    phase_mode  = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_noise = '{70, 75, 0, 0, 0, 64, 0};
    phase_shift = '{6'($urandom_range(0, 63)), 6'd0, 6'd63, 6'($urandom_range(1, 62)),
                    6'd63, 6'd12, 6'($urandom_range(0, 63))};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_reg(TRACE_MODE_ADDR, '0, "trace_mode");
    check_reg(PAGE_SHIFT_ADDR, upsc_pkg::DATA_W'(6), "page_shift");

    // reset settings: single-item trace, then repeats and extremes
    push_req('0, 1'b1, 0, 1'b0);
    push_req('1, 1'b0, 0, 1'b1);
    push_req(64'h3f, 1'b0, 0, 1'b0);
    push_req(64'h40, 1'b0, 1, 1'b0);
    push_req('1, 1'b0, 0, 1'b0);
    push_req(64'h7f, 1'b0, 0, 1'b0);
    push_req(64'h8000_0000_0000_0000, 1'b0, 2, 1'b0);
    push_req(64'h5555_5555_5555_5555, 1'b1, 0, 1'b0);
    push_req(64'h100, 1'b0, 3, 1'b0);
    push_req('0, 1'b0, 0, 1'b0);
    push_req(64'h13f, 1'b1, 0, 1'b0);  // last item repeats an earlier page
    add_random_traces(25, 0);

    for (p = 0; p < 7; p++) begin
      set_config(phase_mode[p], phase_shift[p]);
      if (p == 0) begin
        push_req('1, 1'b0, 0, 1'b0);
        push_req('0, 1'b0, 0, 1'b0);
        push_req(64'hffff_ffff_ffff_fffe, 1'b0, 0, 1'b0);
        push_req('0, 1'b1, 0, 1'b0);
      end
      add_random_traces(25, phase_noise[p]);
    end

    wait_idle();
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
